/* hw/rtl/tfa_pkg.sv */
// ----------------------------------------------------------------------------
// tfa_pkg: shared types and constants for the temporal frame averager
// Payload structs, register map, store geometry, divider and queue constants.
// ----------------------------------------------------------------------------
package tfa_pkg;

	// store geometry
	localparam int TILE_PIXELS  = 4096;
	localparam int MAX_CHANNELS = 4;
	localparam int NUM_LANES    = 4;
	localparam int SUM_W        = 26;
	localparam int ROW_W        = NUM_LANES * SUM_W;
	localparam int PIX_AW       = $clog2(TILE_PIXELS);

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	// configuration
	localparam int DIV_W = 10;
	localparam int CNT_W = 3;
	localparam logic [DIV_W-1:0] DIV_RESET  = 10'd10;
	localparam logic [CNT_W-1:0] CHAN_RESET = 3'd4;
	localparam logic             WIDE_RESET = 1'b0;

	localparam logic [15:0] LIMIT_NARROW = 16'd255;
	localparam logic [15:0] LIMIT_WIDE   = 16'd65535;

	// reciprocal floor(2^RECIP_W / divisions), one quotient bit per cycle
	localparam int RECIP_W     = 32;
	localparam int RECIP_STEPS = RECIP_W + 1;
	localparam int RSTEP_W     = $clog2(RECIP_STEPS + 1);
	localparam logic [RECIP_W-1:0] RECIP_RESET =
		RECIP_W'((64'd1 << RECIP_W) / 64'(DIV_RESET));

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// register map (word index)
	localparam int APB_AW = 4;
	localparam logic [1:0] REG_DIVISIONS = 2'd0;
	localparam logic [1:0] REG_CHANNELS  = 2'd1;
	localparam logic [1:0] REG_WIDE      = 2'd2;

	typedef struct packed {
		logic [11:0] pixel_index;
		logic [9:0]  sample_index;
		logic        source_present;
		logic [15:0] chan_a;
		logic [15:0] chan_b;
		logic [15:0] chan_c;
		logic [15:0] chan_d;
	} sample_t;

	typedef struct packed {
		logic [11:0] out_pixel_index;
		logic [15:0] avg_a;
		logic [15:0] avg_b;
		logic [15:0] avg_c;
		logic [15:0] avg_d;
	} result_t;

endpackage

/* hw/rtl/tfa_ram.sv */
// ----------------------------------------------------------------------------
// tfa_ram: generic simple dual-port RAM
// One write port, one read port, read data registered (valid in the cycle after the read).
// ----------------------------------------------------------------------------
module tfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/temporal_frame_average.sv */
// ----------------------------------------------------------------------------
// temporal_frame_average: per-pixel temporal averaging accumulator
// Sums up to four channels per pixel over frame_divisions samples and emits
// the truncated, clamped average on the last sample.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (valid/ready) takes one pixel sample per clock. Sample 0
//   starts a fresh sum, later samples add to the row in the accumulator RAM,
//   the last one (frame_divisions - 1) produces one transfer on the result
//   channel. Late samples and pixels outside the tile are dropped.
//   Throughput: one sample per cycle while sample_ready is high. The RAM is
//   read as a sample is taken and written back in the next cycle; a hit on
//   the row just written is forwarded from a holding register.
//   The result of a last sample passes the RAM read, sum, reciprocal
//   multiply, remainder multiply and correction before it enters the queue.
//   Results go through an 8-entry queue; sample_ready drops while 8 results
//   are pending, so a stalled receiver backs up into the sample channel.
//   Writing frame_divisions starts a bit-serial reciprocal update;
//   sample_ready is low while the update runs.
//   Reset restores the register defaults and the matching reciprocal; the
//   accumulator RAM is not cleared, sample 0 of each pixel initializes it.
// ----------------------------------------------------------------------------
module temporal_frame_average (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  tfa_pkg::sample_t            sample,
	output logic                        result_valid,
	input  logic                        result_ready,
	output tfa_pkg::result_t            result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tfa_pkg::APB_AW-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import tfa_pkg::*;

	// ---------------- configuration ----------------
	logic [DIV_W-1:0] div_q;
	logic [CNT_W-1:0] chan_cnt_q;
	logic             wide_q;
	logic             apb_wr;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign apb_wr  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q      <= DIV_RESET;
			chan_cnt_q <= CHAN_RESET;
			wide_q     <= WIDE_RESET;
		end else if (apb_wr) begin
			unique case (reg_idx)
				REG_DIVISIONS: div_q      <= pwdata[DIV_W-1:0];
				REG_CHANNELS:  chan_cnt_q <= pwdata[CNT_W-1:0];
				REG_WIDE:      wide_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DIVISIONS: prdata = 32'(div_q);
			REG_CHANNELS:  prdata = 32'(chan_cnt_q);
			REG_WIDE:      prdata = 32'(wide_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------- reciprocal of frame_divisions ----------------
	// restoring division of 2^RECIP_W by div_q, MSB first
	logic               rc_busy_q;
	logic [RSTEP_W-1:0] rc_cnt_q;
	logic [DIV_W-1:0]   rc_rem_q;
	logic [RECIP_W-1:0] recip_q;
	logic               rc_bit;
	logic [DIV_W:0]     rc_trial;
	logic               rc_ge;
	logic [DIV_W-1:0]   rc_rem_nxt;

	always_comb begin
		rc_bit     = (rc_cnt_q == '0);
		rc_trial   = {rc_rem_q, rc_bit};
		rc_ge      = (rc_trial >= {1'b0, div_q});
		rc_rem_nxt = rc_ge ? DIV_W'(rc_trial - {1'b0, div_q}) : rc_trial[DIV_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_busy_q <= 1'b0;
			rc_cnt_q  <= '0;
			rc_rem_q  <= '0;
			recip_q   <= RECIP_RESET;
		end else if (apb_wr && reg_idx == REG_DIVISIONS) begin
			rc_busy_q <= 1'b1;
			rc_cnt_q  <= '0;
			rc_rem_q  <= '0;
		end else if (rc_busy_q) begin
			rc_rem_q <= rc_rem_nxt;
			recip_q  <= {recip_q[RECIP_W-2:0], rc_ge};
			rc_cnt_q <= rc_cnt_q + RSTEP_W'(1);
			if (rc_cnt_q == RSTEP_W'(RECIP_STEPS - 1)) begin
				rc_busy_q <= 1'b0;
			end
		end
	end

	// ---------------- intake ----------------
	logic [FIFO_AW:0]   pend_q;
	logic               acc;
	logic               keep;
	logic               is_last;
	logic [CNT_W-1:0]   used_cnt;
	logic [NUM_LANES-1:0] lane_mask;
	logic [15:0]        chan_in [NUM_LANES];
	logic               pop;

	assign sample_ready = !rc_busy_q && (pend_q < (FIFO_AW+1)'(FIFO_DEPTH));
	assign acc          = sample_valid & sample_ready;
	assign keep         = (sample.sample_index < div_q)
	                      && (int'(sample.pixel_index) < TILE_PIXELS);
	assign is_last      = (sample.sample_index == div_q - DIV_W'(1));

	assign chan_in[0] = sample.chan_a;
	assign chan_in[1] = sample.chan_b;
	assign chan_in[2] = sample.chan_c;
	assign chan_in[3] = sample.chan_d;

	always_comb begin
		used_cnt = (chan_cnt_q > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : chan_cnt_q;
		for (int c = 0; c < NUM_LANES; c++) begin
			lane_mask[c] = (CNT_W'(c) < used_cnt);
		end
	end

	// ---------------- accumulator RAM ----------------
	logic             ram_we;
	logic [ROW_W-1:0] ram_rdata;
	logic [ROW_W-1:0] new_row;

	// ---------------- stage 1: read-modify-write ----------------
	logic                 v_s1;
	logic                 last_s1;
	logic                 first_s1;
	logic [11:0]          pix_s1;
	logic [15:0]          add_s1 [NUM_LANES];
	logic [NUM_LANES-1:0] mask_s1;

	logic             fw_v_q;
	logic [11:0]      fw_pix_q;
	logic [ROW_W-1:0] fw_row_q;

	logic [ROW_W-1:0] old_row;
	logic [SUM_W-1:0] sum_lane [NUM_LANES];

	tfa_ram #(
		.WIDTH (ROW_W),
		.DEPTH (TILE_PIXELS)
	) u_acc_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (PIX_AW'(pix_s1)),
		.wdata (new_row),
		.raddr (PIX_AW'(sample.pixel_index)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc & keep;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= is_last;
		first_s1 <= (sample.sample_index == '0);
		pix_s1   <= sample.pixel_index;
		mask_s1  <= lane_mask;
		for (int c = 0; c < NUM_LANES; c++) begin
			add_s1[c] <= sample.source_present ? chan_in[c] : 16'd0;
		end
	end

	always_comb begin
		logic [SUM_W-1:0] old_c;
		logic [SUM_W:0]   tot_c;
		logic [SUM_W-1:0] sat_c;
		// the row written at the last edge is not yet visible on the read port
		old_row = (fw_v_q && fw_pix_q == pix_s1) ? fw_row_q : ram_rdata;
		for (int c = 0; c < NUM_LANES; c++) begin
			old_c = first_s1 ? '0 : old_row[c*SUM_W +: SUM_W];
			tot_c = {1'b0, old_c} + (SUM_W+1)'(add_s1[c]);
			sat_c = tot_c[SUM_W] ? SUM_MAX : tot_c[SUM_W-1:0];
			// unused lanes keep their stored value and average to zero
			new_row[c*SUM_W +: SUM_W] = mask_s1[c] ? sat_c : old_row[c*SUM_W +: SUM_W];
			sum_lane[c] = mask_s1[c] ? sat_c : '0;
		end
	end

	assign ram_we = v_s1 & ~last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_v_q <= 1'b0;
		end else begin
			fw_v_q <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		fw_pix_q <= pix_s1;
		fw_row_q <= new_row;
	end

	// ---------------- stage 2: sum * reciprocal ----------------
	logic                     v_s2;
	logic [11:0]              pix_s2;
	logic [SUM_W-1:0]         sum_s2 [NUM_LANES];
	logic [SUM_W+RECIP_W-1:0] prod_s2 [NUM_LANES];
	logic [SUM_W-1:0]         qe_s2 [NUM_LANES];

	always_comb begin
		for (int c = 0; c < NUM_LANES; c++) begin
			prod_s2[c] = (SUM_W+RECIP_W)'(sum_s2[c]) * (SUM_W+RECIP_W)'(recip_q);
			// divide by one does not fit the reciprocal register
			qe_s2[c]   = (div_q == DIV_W'(1)) ? sum_s2[c] : prod_s2[c][RECIP_W +: SUM_W];
		end
	end

	// ---------------- stage 3: quotient * divisor ----------------
	logic                   v_s3;
	logic [11:0]            pix_s3;
	logic [SUM_W-1:0]       q_s3 [NUM_LANES];
	logic [SUM_W-1:0]       sum_s3 [NUM_LANES];
	logic [SUM_W+DIV_W-1:0] qd_s3 [NUM_LANES];

	always_comb begin
		for (int c = 0; c < NUM_LANES; c++) begin
			qd_s3[c] = (SUM_W+DIV_W)'(q_s3[c]) * (SUM_W+DIV_W)'(div_q);
		end
	end

	// ---------------- stage 4: correction and clamp ----------------
	logic             v_s4;
	logic [11:0]      pix_s4;
	logic [SUM_W-1:0] q_s4 [NUM_LANES];
	logic [SUM_W-1:0] sum_s4 [NUM_LANES];
	logic [SUM_W-1:0] qd_s4 [NUM_LANES];
	logic [15:0]      avg_s4 [NUM_LANES];
	logic [15:0]      limit;
	result_t          res_s4;

	assign limit = wide_q ? LIMIT_WIDE : LIMIT_NARROW;

	always_comb begin
		logic [SUM_W-1:0] rem_c;
		logic [SUM_W-1:0] qf_c;
		for (int c = 0; c < NUM_LANES; c++) begin
			// estimate is exact or one low
			rem_c = sum_s4[c] - qd_s4[c];
			qf_c  = (rem_c >= SUM_W'(div_q)) ? q_s4[c] + SUM_W'(1) : q_s4[c];
			avg_s4[c] = (qf_c > SUM_W'(limit)) ? limit : qf_c[15:0];
		end
		res_s4.out_pixel_index = pix_s4;
		res_s4.avg_a           = avg_s4[0];
		res_s4.avg_b           = avg_s4[1];
		res_s4.avg_c           = avg_s4[2];
		res_s4.avg_d           = avg_s4[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= v_s1 & last_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		pix_s2 <= pix_s1;
		pix_s3 <= pix_s2;
		pix_s4 <= pix_s3;
		for (int c = 0; c < NUM_LANES; c++) begin
			sum_s2[c] <= sum_lane[c];
			q_s3[c]   <= qe_s2[c];
			sum_s3[c] <= sum_s2[c];
			q_s4[c]   <= q_s3[c];
			sum_s4[c] <= sum_s3[c];
			qd_s4[c]  <= qd_s3[c][SUM_W-1:0];
		end
	end

	// ---------------- result queue ----------------
	result_t          fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   fifo_cnt_q;
	logic               pend_inc;

	assign result_valid = (fifo_cnt_q != '0);
	assign result       = fifo_q[rd_ptr_q];
	assign pop          = result_valid & result_ready;
	assign pend_inc     = acc & keep & is_last;

	always_ff @(posedge clk) begin
		if (v_s4) begin
			fifo_q[wr_ptr_q] <= res_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pend_q     <= '0;
		end else begin
			if (v_s4) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			case ({v_s4, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + (FIFO_AW+1)'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - (FIFO_AW+1)'(1);
				default: ;
			endcase
			// pending results: accepted last samples not yet transferred out
			case ({pend_inc, pop})
				2'b10:   pend_q <= pend_q + (FIFO_AW+1)'(1);
				2'b01:   pend_q <= pend_q - (FIFO_AW+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/tfa_checker.sv */
// ----------------------------------------------------------------------------
// tfa_checker: port-level assertions for temporal_frame_average
// Watches the handshakes and the register port; bound to the top level.
// ----------------------------------------------------------------------------
module tfa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        sample_valid,
	input logic                        sample_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input tfa_pkg::result_t            result,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [tfa_pkg::APB_AW-1:0]  paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);
	import tfa_pkg::*;

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed or dropped while stalled");

	// reciprocal update blocks intake
	a_div_write_stall: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_DIVISIONS
		|=> !sample_ready)
		else $error("sample taken during reciprocal update");

	// a result into an empty queue comes from an earlier sample transfer
	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(sample_valid && sample_ready, 5))
		else $error("result without matching sample transfer");

	// channel count reads back what was written
	a_chan_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_CHANNELS
		|=> (paddr != $past(paddr)) || (prdata == 32'($past(pwdata[CNT_W-1:0]))))
		else $error("channel count readback mismatch");

endmodule

bind temporal_frame_average tfa_checker u_tfa_checker (.*);
